### src/cbtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbtq_pkg
// Shared types and constants of the coalescing bus transaction queue.
// ----------------------------------------------------------------------------
package cbtq_pkg;

	// Ring geometry
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Transaction field widths
	localparam int KIND_W   = 3;
	localparam int BUS_W    = 16;
	localparam int ADDR_W   = 13;
	localparam int DATA_W   = 8;
	localparam int TIME_W   = 64;

	localparam logic [ADDR_W-1:0] ADDR_MASK = 13'h1fff;

	// Request kinds
	localparam logic [KIND_W-1:0] REQ_INJECT_NEXT = 3'd0;
	localparam logic [KIND_W-1:0] REQ_INJECT_AT   = 3'd1;
	localparam logic [KIND_W-1:0] REQ_STUFF       = 3'd2;
	localparam logic [KIND_W-1:0] REQ_RELEASE     = 3'd3;
	localparam logic [KIND_W-1:0] REQ_CONSUME     = 3'd4;

	// One queue entry
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] mask;
		logic [DATA_W-1:0] data;
		logic [TIME_W-1:0] stamp;
		logic              yield;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### src/cbtq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbtq_ctrl
// Two-state sequencer: take a transaction, then decide and commit it once the
// output register is free.
// ----------------------------------------------------------------------------
module cbtq_ctrl
	import cbtq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// Drive commands from the current state
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.commit  = (state_q == ST_EXEC) && sts.out_free;
	end

	// Advance the state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

`default_nettype wire

### src/cbtq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbtq_dp
// Entry ring memory, head/count/next-address pointers, request and read
// registers, push/pop decision and the output register.
// ----------------------------------------------------------------------------
module cbtq_dp
	import cbtq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [KIND_W-1:0] req_type,
	input  wire logic [BUS_W-1:0]  bus_address,
	input  wire logic [BUS_W-1:0]  match_mask,
	input  wire logic [DATA_W-1:0] data_byte,
	input  wire logic [TIME_W-1:0] time_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   accepted,
	output logic [ADDR_W-1:0]      out_address,
	output logic [ADDR_W-1:0]      out_mask,
	output logic [DATA_W-1:0]      out_data,
	output logic [TIME_W-1:0]      out_time,
	output logic                   out_yield
);

	entry_t entry_mem [CAPACITY];

	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] next_addr_q;

	logic [KIND_W-1:0] kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] mask_q;
	logic [DATA_W-1:0] data_q;
	logic [TIME_W-1:0] time_q;

	entry_t head_ent_q;
	entry_t tail_ent_q;

	logic   out_valid_q;
	logic   accepted_q;
	entry_t out_ent_q;

	logic [CNT_W:0]   tail_sum;
	logic [CNT_W:0]   new_sum;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] new_idx;
	logic [IDX_W-1:0] head_nxt;
	logic [IDX_W-1:0] wr_idx;

	entry_t push_ent;
	logic   is_push;
	logic   is_inject;
	logic   not_empty;
	logic   coal;
	logic   push_ok;
	logic   pop_ok;
	logic   ok;
	logic   wr_en;

	assign sts.out_free = !out_valid_q || out_ready;

	// Locate the newest entry and the free slot behind it
	always_comb begin
		tail_sum = {1'b0, CNT_W'(head_q)} + {1'b0, count_q} - (CNT_W+1)'(1);
		if (tail_sum >= (CNT_W+1)'(CAPACITY)) tail_sum = tail_sum - (CNT_W+1)'(CAPACITY);
		tail_idx = tail_sum[IDX_W-1:0];
		new_sum  = {1'b0, CNT_W'(head_q)} + {1'b0, count_q};
		if (new_sum >= (CNT_W+1)'(CAPACITY)) new_sum = new_sum - (CNT_W+1)'(CAPACITY);
		new_idx  = new_sum[IDX_W-1:0];
		head_nxt = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);
	end

	// Build the entry that a push would store
	always_comb begin
		push_ent.addr  = addr_q;
		push_ent.mask  = ADDR_MASK;
		push_ent.data  = data_q;
		push_ent.stamp = time_q;
		push_ent.yield = 1'b0;
		priority if (kind_q == REQ_INJECT_NEXT) begin
			push_ent.addr = next_addr_q;
		end else if (kind_q == REQ_RELEASE) begin
			push_ent.addr  = addr_q & mask_q;
			push_ent.mask  = mask_q;
			push_ent.data  = '0;
			push_ent.yield = 1'b1;
		end else begin
			push_ent.addr = addr_q;
		end
	end

	// Decide between coalesce, append, pop and refuse
	always_comb begin
		is_push   = (kind_q == REQ_INJECT_NEXT) || (kind_q == REQ_INJECT_AT)
			|| (kind_q == REQ_STUFF) || (kind_q == REQ_RELEASE);
		is_inject = (kind_q == REQ_INJECT_NEXT) || (kind_q == REQ_INJECT_AT);
		not_empty = (count_q != '0);
		coal      = not_empty && (tail_ent_q.addr == push_ent.addr)
			&& (tail_ent_q.mask == push_ent.mask);
		push_ok   = coal || (count_q < CNT_W'(CAPACITY));
		pop_ok    = (kind_q == REQ_CONSUME) && not_empty
			&& ((addr_q & head_ent_q.mask) == head_ent_q.addr)
			&& (head_ent_q.stamp <= time_q);
		ok        = is_push ? push_ok : pop_ok;
		wr_en     = cmd.commit && is_push && push_ok;
		wr_idx    = coal ? tail_idx : new_idx;
	end

	// Capture the request and read head and tail entries
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q     <= req_type;
			addr_q     <= bus_address[ADDR_W-1:0];
			mask_q     <= match_mask[ADDR_W-1:0];
			data_q     <= data_byte;
			time_q     <= time_value;
			head_ent_q <= entry_mem[head_q];
			tail_ent_q <= entry_mem[tail_idx];
		end
	end

	// Write the ring memory
	always_ff @(posedge clk) begin
		if (wr_en) entry_mem[wr_idx] <= push_ent;
	end

	// Update pointers on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			next_addr_q <= '0;
		end else if (cmd.commit) begin
			if (wr_en && !coal) count_q <= count_q + CNT_W'(1);
			if (is_inject && push_ok) next_addr_q <= push_ent.addr + ADDR_W'(1);
			if (pop_ok) begin
				head_q  <= head_nxt;
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.commit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			accepted_q <= ok;
			out_ent_q  <= pop_ok ? head_ent_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign out_address = out_ent_q.addr;
	assign out_mask    = out_ent_q.mask;
	assign out_data    = out_ent_q.data;
	assign out_time    = out_ent_q.stamp;
	assign out_yield   = out_ent_q.yield;

endmodule

`default_nettype wire

### src/coalescing_bus_transaction_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_bus_transaction_queue_top
// Ring queue of pending bus transactions with tail coalescing and
// address/time qualified pop.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | req_type bus_address match_mask data_byte
//           |                      | time_value
//   out     | out_valid / out_ready| accepted out_address out_mask out_data
//           |                      | out_time out_yield
//
// Each transaction is accepted in the idle state, whose accept edge reads the head
// and tail entries from the ring memory into registers; the execute state then
// decides and writes back. The registered memory read is why the decision has its own state.
// A result waits in the output register; the next transaction is accepted
// meanwhile and stalls in its decide cycle only while that register is full.
// Reset clears pointers and the output valid; entries need no clearing.
// ----------------------------------------------------------------------------
module coalescing_bus_transaction_queue_top
	import cbtq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [KIND_W-1:0] req_type,
	input  wire logic [BUS_W-1:0]  bus_address,
	input  wire logic [BUS_W-1:0]  match_mask,
	input  wire logic [DATA_W-1:0] data_byte,
	input  wire logic [TIME_W-1:0] time_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   accepted,
	output logic [ADDR_W-1:0]      out_address,
	output logic [ADDR_W-1:0]      out_mask,
	output logic [DATA_W-1:0]      out_data,
	output logic [TIME_W-1:0]      out_time,
	output logic                   out_yield
);

	cmd_t cmd;
	sts_t sts;

	cbtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbtq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.bus_address (bus_address),
		.match_mask  (match_mask),
		.data_byte   (data_byte),
		.time_value  (time_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.out_address (out_address),
		.out_mask    (out_mask),
		.out_data    (out_data),
		.out_time    (out_time),
		.out_yield   (out_yield)
	);

endmodule

`default_nettype wire

### dv/cbtq_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtq_result_checker
// Watches both channels of the coalescing bus transaction queue, keeps its own
// copy of the ring, predicts the result of every accepted transaction and
// compares each returned result with the oldest prediction, field by field.
// It also exposes the predicted head entry, fill level and next inject
// address so that stimulus can aim consumes at the real head.
// ----------------------------------------------------------------------------
module cbtq_result_checker
	import cbtq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [KIND_W-1:0] req_type,
	input  logic [BUS_W-1:0]  bus_address,
	input  logic [BUS_W-1:0]  match_mask,
	input  logic [DATA_W-1:0] data_byte,
	input  logic [TIME_W-1:0] time_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              accepted,
	input  logic [ADDR_W-1:0] out_address,
	input  logic [ADDR_W-1:0] out_mask,
	input  logic [DATA_W-1:0] out_data,
	input  logic [TIME_W-1:0] out_time,
	input  logic              out_yield,
	output int                fail_count,
	output int                results_owed,
	output entry_t            head_entry,
	output logic [CNT_W-1:0]  ring_fill,
	output logic [ADDR_W-1:0] next_inject
);

	typedef struct packed {
		logic              accepted;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] mask;
		logic [DATA_W-1:0] data;
		logic [TIME_W-1:0] stamp;
		logic              yield;
	} result_t;

	entry_t            ring_entries [CAPACITY];
	logic [IDX_W-1:0]  ring_head;
	result_t           awaited_results [$];

	initial fail_count = 0;

	assign head_entry = ring_entries[ring_head];

	task automatic report_mismatch(input string what);
		$display("[%0t] cbtq mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Append at the tail, or overwrite the tail when address and mask agree
	task automatic store_entry(
		input  logic [ADDR_W-1:0] addr,
		input  logic [ADDR_W-1:0] mask,
		input  logic [DATA_W-1:0] data,
		input  logic [TIME_W-1:0] stamp,
		input  logic              yield,
		output logic              ok
	);
		int slot;
		ok = 1'b0;
		if (ring_fill != 0) begin
			slot = (int'(ring_head) + int'(ring_fill) - 1) % CAPACITY;
			if (ring_entries[slot].addr == addr && ring_entries[slot].mask == mask) begin
				ring_entries[slot].data  = data;
				ring_entries[slot].stamp = stamp;
				ring_entries[slot].yield = yield;
				ok = 1'b1;
			end
		end
		if (!ok && ring_fill < CAPACITY) begin
			slot = (int'(ring_head) + int'(ring_fill)) % CAPACITY;
			ring_entries[slot] = '{addr: addr, mask: mask, data: data, stamp: stamp,
				yield: yield};
			ring_fill = ring_fill + 1'b1;
			ok = 1'b1;
		end
	endtask

	// Work out the one result of a transaction and advance the ring copy
	task automatic predict_transaction(
		input  logic [KIND_W-1:0] kind,
		input  logic [BUS_W-1:0]  bus,
		input  logic [BUS_W-1:0]  mask_in,
		input  logic [DATA_W-1:0] data,
		input  logic [TIME_W-1:0] stamp,
		output result_t           res
	);
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] mask;
		logic              ok;
		entry_t            head;
		res  = '0;
		ok   = 1'b0;
		mask = mask_in[ADDR_W-1:0];
		case (kind)
			REQ_INJECT_NEXT, REQ_INJECT_AT: begin
				addr = (kind == REQ_INJECT_NEXT) ? next_inject : bus[ADDR_W-1:0];
				store_entry(addr, ADDR_MASK, data, stamp, 1'b0, ok);
				if (ok)
					next_inject = addr + 1'b1;
			end
			REQ_STUFF: begin
				store_entry(bus[ADDR_W-1:0], ADDR_MASK, data, stamp, 1'b0, ok);
			end
			REQ_RELEASE: begin
				store_entry(bus[ADDR_W-1:0] & mask, mask, '0, stamp, 1'b1, ok);
			end
			REQ_CONSUME: begin
				if (ring_fill != 0) begin
					head = ring_entries[ring_head];
					if ((bus[ADDR_W-1:0] & head.mask) == head.addr && head.stamp <= stamp) begin
						res.addr  = head.addr;
						res.mask  = head.mask;
						res.data  = head.data;
						res.stamp = head.stamp;
						res.yield = head.yield;
						ring_head = IDX_W'((int'(ring_head) + 1) % CAPACITY);
						ring_fill = ring_fill - 1'b1;
						ok = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.accepted = ok;
	endtask

	// Compare returned results first, then record the newly accepted transaction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			ring_head    = '0;
			ring_fill    = '0;
			next_inject  = '0;
			awaited_results.delete();
			results_owed = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result returned with no transaction outstanding");
				end else begin
					want = awaited_results.pop_front();
					if (accepted !== want.accepted)
						report_mismatch($sformatf("accepted got %0h want %0h",
							accepted, want.accepted));
					if (out_address !== want.addr)
						report_mismatch($sformatf("out_address got %0h want %0h",
							out_address, want.addr));
					if (out_mask !== want.mask)
						report_mismatch($sformatf("out_mask got %0h want %0h",
							out_mask, want.mask));
					if (out_data !== want.data)
						report_mismatch($sformatf("out_data got %0h want %0h",
							out_data, want.data));
					if (out_time !== want.stamp)
						report_mismatch($sformatf("out_time got %0h want %0h",
							out_time, want.stamp));
					if (out_yield !== want.yield)
						report_mismatch($sformatf("out_yield got %0h want %0h",
							out_yield, want.yield));
				end
			end
			if (in_valid && in_ready) begin
				predict_transaction(req_type, bus_address, match_mask, data_byte,
					time_value, fresh);
				awaited_results.push_back(fresh);
			end
			results_owed = awaited_results.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the coalescing bus transaction queue: a directed pass over
// edge cases, then bursty random traffic with push-heavy and consume-heavy
// phases, a stalling receiver and long output hold-offs. Checking is done
// by the result checker beside the block; this module drives and decides.
// ----------------------------------------------------------------------------
module testbench;
	import cbtq_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [KIND_W-1:0] req_type    = '0;
	logic [BUS_W-1:0]  bus_address = '0;
	logic [BUS_W-1:0]  match_mask  = '0;
	logic [DATA_W-1:0] data_byte   = '0;
	logic [TIME_W-1:0] time_value  = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              accepted;
	logic [ADDR_W-1:0] out_address;
	logic [ADDR_W-1:0] out_mask;
	logic [DATA_W-1:0] out_data;
	logic [TIME_W-1:0] out_time;
	logic              out_yield;

	int                fail_count;
	int                results_owed;
	entry_t            head_entry;
	logic [CNT_W-1:0]  ring_fill;
	logic [ADDR_W-1:0] next_inject;
	int unsigned       cycle_count = 0;
	logic [TIME_W-1:0] now_stamp   = '0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	coalescing_bus_transaction_queue_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.bus_address (bus_address),
		.match_mask  (match_mask),
		.data_byte   (data_byte),
		.time_value  (time_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.out_address (out_address),
		.out_mask    (out_mask),
		.out_data    (out_data),
		.out_time    (out_time),
		.out_yield   (out_yield)
	);

	cbtq_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.bus_address  (bus_address),
		.match_mask   (match_mask),
		.data_byte    (data_byte),
		.time_value   (time_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.out_address  (out_address),
		.out_mask     (out_mask),
		.out_data     (out_data),
		.out_time     (out_time),
		.out_yield    (out_yield),
		.fail_count   (fail_count),
		.results_owed (results_owed),
		.head_entry   (head_entry),
		.ring_fill    (ring_fill),
		.next_inject  (next_inject)
	);

	// Count cycles and stop a hung run
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("coalescing_bus_transaction_queue_top regression: fail");
		$finish;
	end

	// Offer one transaction at a falling edge, hold it until accepted
	task automatic offer(
		input logic [KIND_W-1:0] kind,
		input logic [BUS_W-1:0]  bus,
		input logic [BUS_W-1:0]  mask,
		input logic [DATA_W-1:0] data,
		input logic [TIME_W-1:0] stamp
	);
		req_type    <= kind;
		bus_address <= bus;
		match_mask  <= mask;
		data_byte   <= data;
		time_value  <= stamp;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Build a consume: 0 aims at the head, 1 is one tick too early, 2 is noise
	task automatic offer_consume(input int shape);
		logic [BUS_W-1:0]  probe;
		logic [TIME_W-1:0] stamp;
		probe = {3'b000, head_entry.addr} | (16'($urandom) & ~{3'b000, head_entry.mask});
		stamp = head_entry.stamp + 64'($urandom_range(0, 3));
		if (stamp < head_entry.stamp)
			stamp = head_entry.stamp;
		if (shape == 1 && head_entry.stamp != 0)
			stamp = head_entry.stamp - 1'b1;
		if (ring_fill == 0 || shape == 2 || (shape == 1 && head_entry.stamp == 0)) begin
			probe = 16'($urandom);
			stamp = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : now_stamp;
		end
		offer(REQ_CONSUME, probe, 16'($urandom), 8'($urandom), stamp);
	endtask

	// Receiver: stall on changing patterns, with two long hold-offs
	initial begin
		int rx_cycle;
		int mode;
		int mode_left;
		rx_cycle  = 0;
		mode      = 0;
		mode_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle == 1500 || rx_cycle == 6000) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_cycle += HOLD_CYCLES;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((rx_cycle % 8) < 5);
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int                items;
		int                burst_left;
		int                push_pct;
		int                roll;
		int                pick;
		logic [KIND_W-1:0] kind;
		logic [BUS_W-1:0]  bus;
		logic [BUS_W-1:0]  mask;
		logic [BUS_W-1:0]  last_bus;
		logic [BUS_W-1:0]  last_mask;
		logic [TIME_W-1:0] stamp;

		items      = 0;
		burst_left = 0;
		push_pct   = 60;
		last_bus   = '0;
		last_mask  = '0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty ring, unknown kinds
		offer(REQ_CONSUME, 16'h0000, 16'h0000, 8'h00, '1);
		for (int k = 1; k <= 3; k++)
			offer(REQ_CONSUME + 3'(k), 16'hffff, 16'hffff, 8'hff, '1);

		// Fill: next-address wrap, coalescing of stuff, release and inject-next
		offer(REQ_INJECT_NEXT, 16'hffff, 16'hffff, 8'h00, 64'd0);
		offer(REQ_INJECT_AT, 16'hffff, 16'h0000, 8'hff, 64'd5);
		offer(REQ_INJECT_NEXT, 16'h0000, 16'h0000, 8'h5a, 64'd7);
		offer(REQ_STUFF, 16'he000, 16'hffff, 8'ha5, 64'd9);
		offer(REQ_RELEASE, 16'hffff, 16'hffff, 8'h00, 64'd11);
		offer(REQ_RELEASE, 16'hffff, 16'hffff, 8'h33, 64'd12);
		offer(REQ_RELEASE, 16'h1234, 16'h0000, 8'h00, '1);
		offer(REQ_INJECT_AT, 16'h2002, 16'h0000, 8'h11, 64'd20);
		offer(REQ_STUFF, 16'h0003, 16'h0000, 8'h22, 64'd21);
		offer(REQ_INJECT_NEXT, 16'h0000, 16'h0000, 8'h33, 64'd22);

		// Drain: match, address miss, stamp too late, masked match
		offer(REQ_CONSUME, 16'h0000, 16'h0000, 8'h00, 64'd0);
		offer(REQ_CONSUME, 16'h0001, 16'h0000, 8'h00, '1);
		offer(REQ_CONSUME, 16'hffff, 16'h0000, 8'h00, 64'd4);
		offer(REQ_CONSUME, 16'hffff, 16'h0000, 8'h00, 64'd5);
		offer(REQ_CONSUME, 16'h8000, 16'h0000, 8'h00, 64'd9);
		offer(REQ_CONSUME, 16'hffff, 16'h0000, 8'h00, '1);
		offer(REQ_CONSUME, 16'h5555, 16'h0000, 8'h00, 64'hffff_ffff_ffff_fffe);
		offer(REQ_CONSUME, 16'h5555, 16'h0000, 8'h00, '1);
		while (ring_fill != 0)
			offer_consume(0);

		// Random traffic in bursts, with phases that favor pushes or pops
		while (items < RANDOM_ITEMS) begin
			if (burst_left == 0) begin
				pause_sender($urandom_range(1, 10));
				burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) :
					$urandom_range(1, 30);
			end
			burst_left--;
			if (items % 150 == 0) begin
				case ($urandom_range(0, 3))
					0: push_pct = 85;
					1: push_pct = 50;
					2: push_pct = 20;
					default: push_pct = 60;
				endcase
			end
			now_stamp = now_stamp + 64'($urandom_range(0, 5));
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				offer(REQ_CONSUME + 3'($urandom_range(1, 3)), 16'($urandom), 16'($urandom),
					8'($urandom), {$urandom, $urandom});
			end else begin
				items++;
				if (roll < push_pct) begin
					case ($urandom_range(0, 3))
						0: kind = REQ_INJECT_NEXT;
						1: kind = REQ_INJECT_AT;
						2: kind = REQ_STUFF;
						default: kind = REQ_RELEASE;
					endcase
					pick = $urandom_range(0, 3);
					if (pick == 0) begin
						// Repeat the last key to coalesce onto the tail
						bus  = last_bus;
						mask = last_mask;
					end else if (pick == 1) begin
						bus  = {3'($urandom), 10'd0, 3'($urandom)};
						mask = 16'($urandom) | 16'h1ff8;
					end else begin
						bus = 16'($urandom);
						case ($urandom_range(0, 5))
							0: mask = 16'hffff;
							1: mask = 16'h0000;
							default: mask = 16'($urandom);
						endcase
					end
					// Aim a stuff at the next inject address now and then
					if (kind == REQ_STUFF && $urandom_range(0, 7) == 0)
						bus = {3'($urandom), next_inject};
					case ($urandom_range(0, 9))
						7, 8: stamp = now_stamp + 64'($urandom_range(1, 20));
						9: stamp = {$urandom, $urandom};
						default: stamp = now_stamp;
					endcase
					last_bus  = bus;
					last_mask = mask;
					offer(kind, bus, mask, 8'($urandom), stamp);
				end else begin
					pick = $urandom_range(0, 9);
					offer_consume((pick < 7) ? 0 : (pick == 7) ? 1 : 2);
				end
			end
		end

		// Wait for the last results, then settle
		in_valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && results_owed == 0)
			$display("coalescing_bus_transaction_queue_top regression: pass");
		else
			$display("coalescing_bus_transaction_queue_top regression: fail");
		$finish;
	end

endmodule
